[rtl/core/sacl_pkg.sv]
`timescale 1ns / 1ps

package sacl_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int OUT_WAY_W   = 3;
    localparam int OUT_SET_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // configuration register widths and reset values
    localparam int SET_BITS_W    = 2;
    localparam int WAYS_IN_USE_W = 4;
    localparam int OFFSET_BITS_W = 5;

    localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 2'd3;
    localparam logic [WAYS_IN_USE_W-1:0] WAYS_IN_USE_RST = 4'd1;
    localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd4;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_WAYS_IN_USE = 2'd1,
        CFG_OFFSET_BITS = 2'd2
    } cfg_reg_t;

    // access word
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              end_of_trace;
    } in_word_t;

    // result word
    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic [OUT_SET_W-1:0] set_index;
        logic [COUNT_W-1:0]   hit_count;
        logic [COUNT_W-1:0]   miss_count;
    } out_word_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic scan;
        logic update;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/core/sacl_ctrl.sv]
`timescale 1ns / 1ps

module sacl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              access_valid,
    input  sacl_pkg::dp_sts_t sts,
    output sacl_pkg::dp_cmd_t cmd,
    output logic              access_stall
);

    sacl_pkg::state_t state_reg;
    sacl_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        access_stall = 1'b1;
        case (state_reg)
            sacl_pkg::ST_IDLE:
            begin
                access_stall = 1'b0;
                if (access_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sacl_pkg::ST_READ;
                end
            end
            sacl_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = sacl_pkg::ST_SCAN;
            end
            sacl_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = sacl_pkg::ST_UPDATE;
                end
            end
            sacl_pkg::ST_UPDATE:
            begin
                // write back only once the result register can take the word
                if (sts.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/sacl_dp.sv]
`timescale 1ns / 1ps

module sacl_dp #(
    parameter int MAX_SETS    = 8,
    parameter int MAX_WAYS    = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sacl_pkg::dp_cmd_t                    cmd,
    output sacl_pkg::dp_sts_t                    sts,
    input  sacl_pkg::in_word_t                   access,
    input  logic [sacl_pkg::SET_BITS_W-1:0]      set_bits,
    input  logic [$clog2(MAX_WAYS+1)-1:0]        nways,
    input  logic [sacl_pkg::OFFSET_BITS_W-1:0]   offset_bits,
    input  logic                                 result_stall,
    output logic                                 result_valid,
    output sacl_pkg::out_word_t                  result
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);
    localparam int ADDR_W = sacl_pkg::ADDR_W;
    localparam int CNT_W  = sacl_pkg::COUNT_W;

    // reduce a raw set number below MAX_SETS
    function automatic logic [SET_W-1:0] set_mod(input logic [2:0] v);
        int r;
        r = int'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= MAX_SETS)
            begin
                r = r - MAX_SETS;
            end
        end
        return SET_W'(r);
    endfunction

    // tag and stamp memories, one row per set
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      tag_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_mem [MAX_SETS];

    logic [MAX_WAYS-1:0][ADDR_W-1:0]      tag_row_reg;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_reg;
    logic [MAX_WAYS-1:0]                  valid_row_reg;
    logic [MAX_SETS-1:0][MAX_WAYS-1:0]    valid_reg;

    // captured access
    logic [ADDR_W-1:0] tag_reg;
    logic [SET_W-1:0]  set_reg;
    logic              last_reg;

    // scan state
    logic [WAY_W-1:0]       idx_reg;
    logic [WAY_W-1:0]       best_reg;
    logic [STAMP_WIDTH-1:0] best_stamp_reg;
    logic                   hit_reg;
    logic [WAY_W-1:0]       hit_way_reg;

    // trace state
    logic [STAMP_WIDTH-1:0] stamp_now_reg;
    logic [CNT_W-1:0]       hits_reg;
    logic [CNT_W-1:0]       misses_reg;
    logic [CNT_W-1:0]       hits_next;
    logic [CNT_W-1:0]       misses_next;

    logic                 res_valid_reg;
    sacl_pkg::out_word_t  result_reg;
    sacl_pkg::out_word_t  result_next;

    logic [ADDR_W-1:0]      line;
    logic [2:0]             set_mask;
    logic [ADDR_W-1:0]      tag_next;
    logic [SET_W-1:0]       set_next;
    logic                   cur_valid;
    logic [STAMP_WIDTH-1:0] cur_stamp;
    logic                   cur_hit;
    logic                   cur_last;
    logic [WAY_W-1:0]       way_sel;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      tag_wr_row;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_wr_row;

    // address split
    always_comb
    begin
        line     = access.address >> offset_bits;
        set_mask = 3'((4'd1 << set_bits) - 4'd1);
        tag_next = line >> set_bits;
        set_next = set_mod(line[2:0] & set_mask);
    end

    // one way per scan cycle; unfilled ways count as stamp zero
    always_comb
    begin
        cur_valid     = valid_row_reg[idx_reg];
        cur_stamp     = cur_valid ? stamp_row_reg[idx_reg] : '0;
        cur_hit       = cur_valid && (tag_row_reg[idx_reg] == tag_reg);
        cur_last      = (NW_W'(idx_reg) + NW_W'(1)) == nways;
        sts.scan_done = cur_hit || cur_last;
        sts.out_free  = !res_valid_reg || !result_stall;
    end

    // write-back rows and result word
    always_comb
    begin
        way_sel               = hit_reg ? hit_way_reg : best_reg;
        tag_wr_row            = tag_row_reg;
        tag_wr_row[way_sel]   = tag_reg;
        stamp_wr_row          = stamp_row_reg;
        stamp_wr_row[way_sel] = stamp_now_reg;

        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (hit_reg)
        begin
            if (hits_reg != '1)
            begin
                hits_next = hits_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (misses_reg != '1)
            begin
                misses_next = misses_reg + CNT_W'(1);
            end
        end

        result_next.hit        = hit_reg;
        result_next.way        = sacl_pkg::OUT_WAY_W'(way_sel);
        result_next.set_index  = sacl_pkg::OUT_SET_W'(set_reg);
        result_next.hit_count  = hits_next;
        result_next.miss_count = misses_next;
    end

    // memories and row buffers
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            tag_row_reg   <= tag_mem[set_reg];
            stamp_row_reg <= stamp_mem[set_reg];
            valid_row_reg <= valid_reg[set_reg];
        end
        if (cmd.update)
        begin
            stamp_mem[set_reg] <= stamp_wr_row;
            if (!hit_reg)
            begin
                tag_mem[set_reg] <= tag_wr_row;
            end
        end
    end

    // captured access and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg  <= tag_next;
            set_reg  <= set_next;
            last_reg <= access.end_of_trace;
        end
        if (cmd.update)
        begin
            result_reg <= result_next;
        end
    end

    // scan, trace and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            best_reg       <= '0;
            best_stamp_reg <= '0;
            hit_reg        <= 1'b0;
            hit_way_reg    <= '0;
            valid_reg      <= '0;
            stamp_now_reg  <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.read)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_reg + WAY_W'(1);
                if (cur_hit)
                begin
                    hit_reg     <= 1'b1;
                    hit_way_reg <= idx_reg;
                end
                else if ((idx_reg == '0) || (cur_stamp < best_stamp_reg))
                begin
                    // strict compare keeps the lowest way on ties
                    best_reg       <= idx_reg;
                    best_stamp_reg <= cur_stamp;
                end
            end
            if (cmd.update)
            begin
                if (last_reg)
                begin
                    valid_reg     <= '0;
                    stamp_now_reg <= '0;
                    hits_reg      <= '0;
                    misses_reg    <= '0;
                end
                else
                begin
                    valid_reg[set_reg][way_sel] <= 1'b1;
                    stamp_now_reg <= stamp_now_reg + STAMP_WIDTH'(1);
                    hits_reg      <= hits_next;
                    misses_reg    <= misses_next;
                end
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/core/set_assoc_lru_cache_tags.sv]
`timescale 1ns / 1ps
// Tag store of a set-associative cache with timestamp LRU replacement.
// Access channel: access_valid / access_stall carry one word with a byte
// address and an end_of_trace flag. Result channel: result_valid /
// result_stall carry hit, way, set_index and the running, saturating hit and
// miss counts. A word moves when valid is high and stall is low.
// Configuration: cfg_write with cfg_index 0 (set_bits), 1 (ways_in_use) or
// 2 (offset_bits) and cfg_data; write only while no access is in flight.
// One access at a time: accept, a set read, a way-by-way scan of the set and
// a write-back. The scan stops at the way that hits, or for a miss once all
// n ways in use have been scanned; the result shows in the cycle after the
// write-back. The scan over the ways sets the length of an access.
// A stalled result holds in its register; the next access is taken and
// scanned meanwhile, and its write-back waits until the register frees.
// An access flagged end_of_trace clears the store, counters and stamp after
// its result is formed. Reset clears the same at once through per-way valid
// bits (no clearing pass) and loads the configuration defaults 3, 1 and 4.
module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS    = 8,
    parameter int MAX_WAYS    = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 access_valid,
    output logic                                 access_stall,
    input  sacl_pkg::in_word_t                   access,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output sacl_pkg::out_word_t                  result,
    input  logic                                 cfg_write,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NW_W = $clog2(MAX_WAYS + 1);

    logic [sacl_pkg::SET_BITS_W-1:0]    set_bits_reg;
    logic [sacl_pkg::WAYS_IN_USE_W-1:0] ways_in_use_reg;
    logic [sacl_pkg::OFFSET_BITS_W-1:0] offset_bits_reg;
    logic [NW_W-1:0]                    nways;

    sacl_pkg::dp_cmd_t cmd;
    sacl_pkg::dp_sts_t sts;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= sacl_pkg::SET_BITS_RST;
            ways_in_use_reg <= sacl_pkg::WAYS_IN_USE_RST;
            offset_bits_reg <= sacl_pkg::OFFSET_BITS_RST;
        end
        else if (cfg_write)
        begin
            case (sacl_pkg::cfg_reg_t'(cfg_index))
                sacl_pkg::CFG_SET_BITS:
                begin
                    set_bits_reg <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
                end
                sacl_pkg::CFG_WAYS_IN_USE:
                begin
                    ways_in_use_reg <= cfg_data[sacl_pkg::WAYS_IN_USE_W-1:0];
                end
                sacl_pkg::CFG_OFFSET_BITS:
                begin
                    offset_bits_reg <= cfg_data[sacl_pkg::OFFSET_BITS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ways in use, zero taken as one and clamped to the array
    always_comb
    begin
        if (ways_in_use_reg == '0)
        begin
            nways = NW_W'(1);
        end
        else if (32'(ways_in_use_reg) > 32'(MAX_WAYS))
        begin
            nways = NW_W'(MAX_WAYS);
        end
        else
        begin
            nways = NW_W'(ways_in_use_reg);
        end
    end

    sacl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .sts          (sts),
        .cmd          (cmd),
        .access_stall (access_stall)
    );

    sacl_dp #(
        .MAX_SETS    (MAX_SETS),
        .MAX_WAYS    (MAX_WAYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .access       (access),
        .set_bits     (set_bits_reg),
        .nways        (nways),
        .offset_bits  (offset_bits_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[rtl/core/sacl_checker.sv]
`timescale 1ns / 1ps

module sacl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                access_valid,
    input logic                access_stall,
    input logic                result_valid,
    input logic                result_stall,
    input sacl_pkg::out_word_t result
);

    // one access in flight: the port closes right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        access_valid && !access_stall |=> access_stall)
        else $error("access taken while previous access still in flight");

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // a hit result counts itself
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hit |-> result.hit_count != '0)
        else $error("hit reported with zero hit count");

    // a miss result counts itself
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.hit |-> result.miss_count != '0)
        else $error("miss reported with zero miss count");

endmodule

bind set_assoc_lru_cache_tags sacl_checker u_sacl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[tb/set_assoc_lru_cache_tags_test.sv]
`timescale 1ns / 1ps

import sacl_pkg::*;

// predicts hit/miss, way and counters for each access and checks the results
class cache_scoreboard;
    localparam int WAY_SLOTS = 8;
    localparam int SET_SLOTS = 8;

    logic [ADDR_W-1:0]        tag_mem   [SET_SLOTS*WAY_SLOTS];
    bit                       line_live [SET_SLOTS*WAY_SLOTS];
    logic [31:0]              stamp_mem [SET_SLOTS*WAY_SLOTS];
    logic [31:0]              access_num;
    logic [COUNT_W-1:0]       hits;
    logic [COUNT_W-1:0]       misses;

    logic [SET_BITS_W-1:0]    set_bits;
    logic [WAYS_IN_USE_W-1:0] ways;
    logic [OFFSET_BITS_W-1:0] offset;

    out_word_t                outcome_q[$];
    int                       errors;

    function new();
        clear_trace();
        set_bits = SET_BITS_RST;
        ways     = WAYS_IN_USE_RST;
        offset   = OFFSET_BITS_RST;
        errors   = 0;
    endfunction

    function void clear_trace();
        foreach (tag_mem[i])
        begin
            tag_mem[i]   = '0;
            line_live[i] = 1'b0;
            stamp_mem[i] = '0;
        end
        access_num = '0;
        hits       = '0;
        misses     = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SET_BITS:    set_bits = data[SET_BITS_W-1:0];
            CFG_WAYS_IN_USE: ways     = data[WAYS_IN_USE_W-1:0];
            CFG_OFFSET_BITS: offset   = data[OFFSET_BITS_W-1:0];
            default: ;
        endcase
    endfunction

    // zero ways acts as one, more than the store holds is clipped
    function int live_ways();
        if (ways == 0)
            return 1;
        if (ways > WAY_SLOTS)
            return WAY_SLOTS;
        return ways;
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    // lookup and LRU fill for one accepted access word
    function void note_access(in_word_t w);
        logic [ADDR_W-1:0]    line;
        logic [ADDR_W-1:0]    tag;
        logic [31:0]          best_stamp;
        logic [OUT_SET_W-1:0] set_sel;
        int                   nways;
        int                   base;
        int                   best;
        int                   hit_way;
        bit                   hit;
        out_word_t            want;

        line    = w.address >> offset;
        set_sel = line[OUT_SET_W-1:0] & 3'((4'd1 << set_bits) - 4'd1);
        tag     = line >> set_bits;
        nways   = live_ways();
        base    = int'(set_sel) * WAY_SLOTS;

        best_stamp = stamp_mem[base];
        best       = 0;
        hit        = 1'b0;
        hit_way    = 0;
        for (int j = 0; j < nways; j++)
        begin
            if (!hit)
            begin
                if (line_live[base+j] && tag_mem[base+j] == tag)
                begin
                    hit     = 1'b1;
                    hit_way = j;
                end
                else if (stamp_mem[base+j] < best_stamp)
                begin
                    best_stamp = stamp_mem[base+j];
                    best       = j;
                end
            end
        end

        if (hit)
        begin
            stamp_mem[base+hit_way] = access_num;
            if (hits != '1)
                hits++;
        end
        else
        begin
            stamp_mem[base+best] = access_num;
            line_live[base+best] = 1'b1;
            tag_mem[base+best]   = tag;
            hit_way              = best;
            if (misses != '1)
                misses++;
        end
        access_num++;

        want.hit        = hit;
        want.way        = OUT_WAY_W'(hit_way);
        want.set_index  = set_sel;
        want.hit_count  = hits;
        want.miss_count = misses;
        outcome_q.push_back(want);

        if (w.end_of_trace)
            clear_trace();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_result(out_word_t got);
        out_word_t want;

        if (outcome_q.size() == 0)
        begin
            $display("%0t: result word with nothing expected, expected none, got %h",
                     $time, got);
            errors++;
            return;
        end
        want = outcome_q.pop_front();
        compare_field("hit", want.hit, got.hit);
        compare_field("way", want.way, got.way);
        compare_field("set_index", want.set_index, got.set_index);
        compare_field("hit_count", want.hit_count, got.hit_count);
        compare_field("miss_count", want.miss_count, got.miss_count);
    endfunction
endclass

module set_assoc_lru_cache_tags_test;

    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   access_valid;
    logic                   access_stall;
    in_word_t               access;
    logic                   result_valid;
    logic                   result_stall;
    out_word_t              result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cache_scoreboard        sb;
    in_word_t               access_plan[$];
    bit                     calm;
    bit                     hold_req;

    set_assoc_lru_cache_tags u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .access       (access),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic void queue_access(logic [ADDR_W-1:0] addr, logic last);
        in_word_t w;
        w.address      = addr;
        w.end_of_trace = last;
        access_plan.push_back(w);
    endfunction

    // one access word, entered and left at a falling edge
    task automatic send_word(input in_word_t w);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            access_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        access_valid <= 1'b1;
        access       <= w;
        do
            @(posedge clk);
        while (access_stall);
        sb.note_access(w);
        @(negedge clk);
    endtask

    // send the queued words and wait for all their results
    task automatic run_plan();
        @(negedge clk);
        while (access_plan.size() != 0)
            send_word(access_plan.pop_front());
        access_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // result side back-pressure, including the long hold-off
    initial
    begin : receiver
        int stall_run;
        stall_run    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (300) @(negedge clk);
                result_stall <= 1'b0;
                stall_run = 0;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                result_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_run = pick_gap() - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // stimulus
    initial
    begin : stimulus
        int                       sb_tab[7];
        int                       ways_tab[7];
        int                       off_tab[7];
        int                       nsets;
        int                       pool_n;
        int                       n_items;
        logic [ADDR_W-1:0]        pool[$];
        logic [ADDR_W-1:0]        mask;
        logic [ADDR_W-1:0]        addr;
        logic [SET_BITS_W-1:0]    sb_val;
        logic [WAYS_IN_USE_W-1:0] ways_val;
        logic [OFFSET_BITS_W-1:0] off_val;

        sb_tab   = '{0, 3, 1, 2, 3, 0, 2};
        ways_tab = '{0, 8, 15, 4, 9, 1, 3};
        off_tab  = '{0, 16, 31, 5, 0, 12, 20};

        sb           = new();
        calm         = 1'b0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        access_valid = 1'b0;
        access       = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_SET_BITS;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // direct-mapped at reset values: line offset, eviction, trace end
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'hFFFF_FFFF, 1'b0);
        queue_access(32'h0000_000F, 1'b0);
        queue_access(32'h0000_0080, 1'b0);
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'hFFFF_FFF0, 1'b1);
        queue_access(32'hFFFF_FFFF, 1'b0);
        queue_access(32'h8000_0000, 1'b0);
        queue_access(32'h7FFF_FFFF, 1'b0);
        run_plan();

        // eight ways on one set: fill, refresh, evict the oldest
        write_reg(CFG_WAYS_IN_USE, 5'd8);
        for (int k = 0; k <= 8; k++)
            queue_access(ADDR_W'(k) << 7, 1'b0);
        queue_access(32'h0000_0000, 1'b0);
        queue_access(32'h0000_0100, 1'b1);
        run_plan();

        // fixed extremes first, then random settings
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph < 7)
            begin
                sb_val   = SET_BITS_W'(sb_tab[ph]);
                ways_val = WAYS_IN_USE_W'(ways_tab[ph]);
                off_val  = OFFSET_BITS_W'(off_tab[ph]);
                write_reg(CFG_SET_BITS, {3'($urandom), sb_val});
                write_reg(CFG_WAYS_IN_USE, {1'($urandom), ways_val});
                write_reg(CFG_OFFSET_BITS, off_val);
            end
            else
            begin
                if ($urandom_range(0, 1))
                    write_reg(CFG_SET_BITS, 5'($urandom));
                if ($urandom_range(0, 1))
                    write_reg(CFG_WAYS_IN_USE, 5'($urandom));
                if ($urandom_range(0, 1))
                    write_reg(CFG_OFFSET_BITS, 5'($urandom));
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_NO_REG, 5'($urandom));
            end

            // working set sized to the cache so both hits and evictions occur
            nsets  = 1 << sb.set_bits;
            pool_n = $urandom_range(1, 2 * nsets * sb.live_ways());
            pool.delete();
            repeat (pool_n) pool.push_back($urandom);
            mask    = (32'd1 << sb.offset) - 32'd1;
            n_items = 140 + $urandom_range(0, 20);
            repeat (n_items)
            begin
                if ($urandom_range(0, 99) < 85)
                    addr = (pool[$urandom_range(0, pool_n - 1)] & ~mask) | ($urandom & mask);
                else
                    addr = $urandom;
                queue_access(addr, $urandom_range(0, 119) == 0);
            end

            // one phase with a full-rate sender against a long result hold-off
            calm = (ph == 2) || ($urandom_range(0, 4) == 0);
            if (ph == 2)
                hold_req = 1'b1;
            run_plan();
            calm = 1'b0;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
